### design/prsum_pkg.sv
// shared constants and types for the prime sum core
`default_nettype none
package prsum_pkg;
	localparam int LIMIT_W      = 16;
	localparam int CAND_W       = LIMIT_W + 1;
	localparam int SQ_W         = 2 * CAND_W;
	localparam int SUM_W        = 28;
	localparam int IN_TDATA_W   = ((LIMIT_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((SUM_W + 7) / 8) * 8;
	localparam int DIV_BITS     = 4;
	localparam int DIV_STEPS    = (CAND_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DVD_W        = DIV_STEPS * DIV_BITS;
	localparam int CNT_W        = $clog2(DIV_STEPS + 1);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;
endpackage
`default_nettype wire

### design/prime_sum_up_to_limit_core.sv
// prime sum core: sums all primes up to a limit by 6k+-1 trial division
//
// channel  dir  fields (tdata from bit 0)          accept
// s_*      in   limit [LIMIT_W-1:0], zero padded    s_tvalid & s_tready
// m_*      out  prime_sum [27:0], zero padded       m_tvalid & m_tready
//
// one item at a time: s_tready is high only while the sequencer is idle
// each candidate is first screened in ST_NEXT; multiples of 2 or 3 stop there
// each 6k-1/6k+1 divisor pair is first held against d squared in ST_CHECK, then
// tried in ST_DIV on the shared remainder unit that retires 4 quotient bits per cycle
// the result sits in an output register, so a new item is taken while it waits
// arst_n clears the sequencer and the output valid; data registers are not reset
`default_nettype none
module prime_sum_up_to_limit_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [prsum_pkg::IN_TDATA_W-1:0]     s_tdata,   // limit
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [prsum_pkg::OUT_TDATA_W-1:0]   m_tdata    // prime_sum
);
	import prsum_pkg::*;

	state_t state_q, state_d;

	// walk registers
	logic [LIMIT_W-1:0] lim_q;
	logic [CAND_W-1:0]  cand_q;
	logic [2:0]         mod6_q;      // cand_q mod 6, tracked beside the candidate
	logic [CAND_W-1:0]  d_q;         // current 6k-1 divisor
	logic [SQ_W-1:0]    sq_q;        // d_q squared, kept by increments
	logic [SUM_W-1:0]   sum_q;

	// shared remainder unit
	logic [CAND_W-1:0]  rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [CAND_W-1:0]  div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               sel_q;       // 0: dividing by d, 1: by d+2

	logic [SUM_W-1:0]   out_q;
	logic               out_vld_q;

	// control strobes from the sequencer
	logic ld_start, cand_adv, add_prime, start_div, start_div2, div_run, next_pair, ld_out;

	// remainder step results
	logic [CAND_W-1:0]  rem_nx;
	logic [DVD_W-1:0]   dvd_nx;
	logic [CAND_W:0]    trial;
	logic               last_step;
	logic               cand_over;
	logic               cand_small;
	logic               cand_coprime;
	logic               sq_above;
	logic [SUM_W:0]     sum_wide;

	assign last_step    = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign cand_over    = (cand_q > {1'b0, lim_q});
	assign cand_small   = (cand_q <= CAND_W'(3));
	assign cand_coprime = (mod6_q == 3'd1) || (mod6_q == 3'd5);
	assign sq_above     = (sq_q > SQ_W'(cand_q));
	assign sum_wide     = {1'b0, sum_q} + (SUM_W + 1)'(cand_q);

	// radix-16 restoring remainder step, four dependent subtract-compares
	always_comb begin
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		trial  = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial  = {rem_nx, dvd_nx[DVD_W-1]};
			dvd_nx = {dvd_nx[DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_nx = trial[CAND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		ld_start   = 1'b0;
		cand_adv   = 1'b0;
		add_prime  = 1'b0;
		start_div  = 1'b0;
		start_div2 = 1'b0;
		div_run    = 1'b0;
		next_pair  = 1'b0;
		ld_out     = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ld_start = 1'b1;
					state_d  = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (cand_over) begin
					state_d = ST_FINISH;
				end else if (cand_small) begin
					add_prime = 1'b1;
					cand_adv  = 1'b1;
				end else if (!cand_coprime) begin
					cand_adv = 1'b1;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sq_above) begin
					add_prime = 1'b1;
					cand_adv  = 1'b1;
					state_d   = ST_NEXT;
				end else begin
					start_div = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!last_step) begin
					div_run = 1'b1;
				end else if (rem_nx == '0) begin
					// divisor found, composite
					cand_adv = 1'b1;
					state_d  = ST_NEXT;
				end else if (!sel_q) begin
					start_div2 = 1'b1;
				end else begin
					next_pair = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!out_vld_q || m_tready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (ld_start) begin
			lim_q  <= s_tdata[LIMIT_W-1:0];
			cand_q <= CAND_W'(2);
			mod6_q <= 3'd2;
			sum_q  <= '0;
		end else begin
			if (add_prime) begin
				sum_q <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
			end
			if (cand_adv) begin
				cand_q <= cand_q + 1'b1;
				mod6_q <= (mod6_q == 3'd5) ? 3'd0 : mod6_q + 3'd1;
			end
		end
		if (state_q == ST_NEXT) begin
			d_q  <= CAND_W'(5);
			sq_q <= SQ_W'(25);
		end else if (next_pair) begin
			d_q  <= d_q + CAND_W'(6);
			sq_q <= sq_q + (SQ_W'(d_q) << 3) + (SQ_W'(d_q) << 2) + SQ_W'(36);
		end
	end

	// remainder unit registers
	always_ff @(posedge clk) begin
		if (start_div || start_div2) begin
			rem_q <= '0;
			dvd_q <= DVD_W'(cand_q);
			cnt_q <= '0;
			sel_q <= start_div2;
			div_q <= start_div2 ? d_q + CAND_W'(2) : d_q;
		end else if (div_run) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q <= sum_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

	// trial divisors are always odd and at least five
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q[0] && div_q >= CAND_W'(5)))
		else $error("trial divisor not odd or below five");

	// the residue counter stays below six
	a_mod6: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT || state_q == ST_CHECK) |-> (mod6_q < 3'd6))
		else $error("candidate residue out of range");

	// an accepted limit starts the walk on the next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_NEXT && cand_q == CAND_W'(2)))
		else $error("walk did not start at two");

	// a result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> (!out_vld_q || m_tready))
		else $error("pending result overwritten");

	// squared divisor stays consistent with the divisor
	a_square: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (sq_q == SQ_W'(d_q) * SQ_W'(d_q)))
		else $error("divisor square out of step");
endmodule
`default_nettype wire
